FILE: design/adcseg_pkg.sv
// adcseg_pkg: shared constants, types and helper functions for the adc to
// seven-segment reading pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adcseg_pkg;

    // default sizes of the block
    localparam int ADC_BITS_DEF    = 10;
    localparam int DIGIT_COUNT_DEF = 4;

    // calibration register
    localparam int                  OFFSET_W     = 17;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd32431;

    // result word
    localparam int READING_W    = 14;
    localparam int SEG_W        = 7;
    localparam int SHOWN_DIGITS = 4;

    // scaling: value = (sample*100 - offset) * 50 / 61
    localparam int SAMPLE_SCALE = 100;
    localparam int SCALE_NUM    = 50;
    localparam int SCALE_DEN    = 61;

    // range flags that travel with a word
    typedef struct packed {
        logic over;
        logic under;
    } t_range;

    // ten to the power k, elaboration only
    function automatic longint pow10(input int k);
        longint acc;
        acc = 1;
        for (int i = 0; i < k; i++) begin
            acc = acc * 10;
        end
        return acc;
    endfunction

    // segment code in gfedcba order
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: design/adcseg_scale.sv
// adcseg_scale: input register, offset and scale, saturation and exact
// division by 61 through a reciprocal multiply. Uses adcseg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adcseg_scale
    import adcseg_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
    localparam int VAL_W      = $clog2(pow10(DIGIT_COUNT))
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output      logic                o_stall,
    input  wire logic [ADC_BITS-1:0] i_adc_sample,
    input  wire logic [OFFSET_W-1:0] i_offset_centi,
    output      logic                o_valid,
    input  wire logic                i_stall,
    output      logic [VAL_W-1:0]    o_value,
    output      t_range              o_range
);

    // scaled numerator p = sample*5000 - offset*50, signed
    localparam int FULL_W = ((ADC_BITS + 13 > OFFSET_W + 6) ? ADC_BITS + 13 : OFFSET_W + 6) + 1;
    // p at or above this saturates
    localparam longint LIMIT_P = longint'(SCALE_DEN) * pow10(DIGIT_COUNT);
    localparam int     PW      = $clog2(LIMIT_P);
    localparam int     CMP_W   = (FULL_W > PW + 1) ? FULL_W : PW + 1;
    // exact reciprocal of 61 for a PW-bit dividend
    localparam int     RL      = $clog2(SCALE_DEN);
    localparam int     SHIFT   = PW + RL;
    localparam longint RECIP   = ((64'sd1 <<< SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
    localparam int     PROD_W  = 2 * PW + 1;

    localparam logic signed [CMP_W-1:0] OVER_P  = CMP_W'(LIMIT_P);
    localparam logic signed [CMP_W-1:0] UNDER_P = CMP_W'(-(SCALE_DEN - 1));
    localparam logic [VAL_W-1:0]        MAX_VAL = VAL_W'(pow10(DIGIT_COUNT) - 1);

    logic                r_vld_a, r_vld_b, r_vld_c;
    logic                rdy_a, rdy_b, rdy_c;
    logic [ADC_BITS-1:0] r_sample;
    logic [PW-1:0]       r_p;
    logic [PW-1:0]       n_p;
    t_range              r_range_b, n_range_b, r_range_c;
    logic [VAL_W-1:0]    r_value, n_value;

    logic signed [FULL_W-1:0] p_full;
    logic signed [CMP_W-1:0]  p_ext;
    logic [PROD_W-1:0]        prod;

    // per-stage ready, bubbles collapse
    assign rdy_c   = !r_vld_c || !i_stall;
    assign rdy_b   = !r_vld_b || rdy_c;
    assign rdy_a   = !r_vld_a || rdy_b;
    assign o_stall = !rdy_a;

    // stage a: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (rdy_a) begin
            r_vld_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_sample <= i_adc_sample;
        end
    end

    // stage b: numerator and range checks
    assign p_full = $signed(FULL_W'(r_sample) * FULL_W'(SAMPLE_SCALE * SCALE_NUM))
                  - $signed(FULL_W'(i_offset_centi) * FULL_W'(SCALE_NUM));
    assign p_ext  = CMP_W'(p_full);

    always_comb begin
        n_range_b.under = (p_ext < UNDER_P);
        n_range_b.over  = (p_ext >= OVER_P);
        // small negatives truncate to a plain zero
        if (p_ext < 0 || n_range_b.over) begin
            n_p = '0;
        end else begin
            n_p = p_ext[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (rdy_b) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_vld_a) begin
            r_p       <= n_p;
            r_range_b <= n_range_b;
        end
    end

    // stage c: divide by 61, saturate
    assign prod = PROD_W'(r_p) * PROD_W'(RECIP);

    always_comb begin
        if (r_range_b.over) begin
            n_value = MAX_VAL;
        end else begin
            n_value = VAL_W'(prod >> SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
        end else if (rdy_c) begin
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && r_vld_b) begin
            r_value   <= n_value;
            r_range_c <= r_range_b;
        end
    end

    assign o_valid = r_vld_c;
    assign o_value = r_value;
    assign o_range = r_range_c;

endmodule

`default_nettype wire

FILE: design/adcseg_digits.sv
// adcseg_digits: decimal split of the saturated reading and seven-segment
// encoding with leading-digit blanking. Uses adcseg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adcseg_digits
    import adcseg_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
    localparam int VAL_W      = $clog2(pow10(DIGIT_COUNT))
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output      logic                                o_stall,
    input  wire logic [VAL_W-1:0]                    i_value,
    input  wire t_range                              i_range,
    output      logic                                o_valid,
    input  wire logic                                i_stall,
    output      logic [READING_W-1:0]                o_reading_centi,
    output      logic [SHOWN_DIGITS-1:0][SEG_W-1:0]  o_segs,
    output      t_range                              o_range
);

    localparam int EXT_W = (VAL_W > READING_W) ? VAL_W : READING_W;
    localparam int PRW   = 2 * VAL_W + 1;

    logic                                 r_vld_d, r_vld_e;
    logic                                 rdy_d, rdy_e;
    logic [DIGIT_COUNT-1:0][VAL_W-1:0]    r_t, n_t;
    t_range                               r_range_d, r_range_e;
    logic [SHOWN_DIGITS-1:0][SEG_W-1:0]   r_segs, n_segs;
    logic [READING_W-1:0]                 r_reading, n_reading;
    logic [EXT_W-1:0]                     value_ext;

    assign rdy_e   = !r_vld_e || !i_stall;
    assign rdy_d   = !r_vld_d || rdy_e;
    assign o_stall = !rdy_d;

    // stage d: value / 10^k for each position, all in parallel
    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_quot
        localparam longint DIV   = pow10(k);
        localparam int     SH    = VAL_W + $clog2(DIV);
        localparam longint RECIP = ((64'sd1 <<< SH) + DIV - 1) / DIV;
        logic [PRW-1:0] prod;
        assign prod   = PRW'(i_value) * PRW'(RECIP);
        assign n_t[k] = VAL_W'(prod >> SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= 1'b0;
        end else if (rdy_d) begin
            r_vld_d <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_d && i_valid) begin
            r_t       <= n_t;
            r_range_d <= i_range;
        end
    end

    // stage e: digit = q(k) - 10*q(k+1), blank above the leading digit
    for (genvar k = 0; k < SHOWN_DIGITS; k++) begin : g_seg
        if (k < DIGIT_COUNT) begin : g_used
            logic [VAL_W-1:0] upper_x10;
            logic [VAL_W-1:0] digit;
            if (k + 1 < DIGIT_COUNT) begin : g_mid
                assign upper_x10 = VAL_W'(r_t[k+1] * VAL_W'(10));
            end else begin : g_top
                assign upper_x10 = '0;
            end
            assign digit = r_t[k] - upper_x10;
            if (k == 0) begin : g_ones
                assign n_segs[k] = seg_code(digit[3:0]);
            end else begin : g_upper
                assign n_segs[k] = (r_t[k] != '0) ? seg_code(digit[3:0]) : '0;
            end
        end else begin : g_unused
            assign n_segs[k] = '0;
        end
    end

    assign value_ext = EXT_W'(r_t[0]);
    assign n_reading = value_ext[READING_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e <= 1'b0;
        end else if (rdy_e) begin
            r_vld_e <= r_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_e && r_vld_d) begin
            r_segs    <= n_segs;
            r_reading <= n_reading;
            r_range_e <= r_range_d;
        end
    end

    assign o_valid         = r_vld_e;
    assign o_reading_centi = r_reading;
    assign o_segs          = r_segs;
    assign o_range         = r_range_e;

endmodule

`default_nettype wire

FILE: design/adc_to_seven_segment_temp.sv
// Path: an accepted word moves through the register stages below in order, then shows on o_valid.
// Throughput: one word per cycle while i_stall is low; five register stages (input, numerator,
// divide by 61, decimal split, segment encode) each hold one word.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// calibration offset with 32431.
// Top level: calibration register and the two pipeline halves. Uses adcseg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adc_to_seven_segment_temp
    import adcseg_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [OFFSET_W-1:0]  i_cfg_data,
    input  wire logic                 i_valid,
    output      logic                 o_stall,
    input  wire logic [ADC_BITS-1:0]  i_adc_sample,
    output      logic                 o_valid,
    input  wire logic                 i_stall,
    output      logic [READING_W-1:0] o_reading_centi,
    output      logic [SEG_W-1:0]     o_seg_thousands,
    output      logic [SEG_W-1:0]     o_seg_hundreds,
    output      logic [SEG_W-1:0]     o_seg_tens,
    output      logic [SEG_W-1:0]     o_seg_ones,
    output      logic                 o_over_range,
    output      logic                 o_under_range
);

    localparam int VAL_W = $clog2(pow10(DIGIT_COUNT));

    logic [OFFSET_W-1:0]                r_offset_centi;
    logic                               mid_valid, mid_stall;
    logic [VAL_W-1:0]                   mid_value;
    t_range                             mid_range, out_range;
    logic [SHOWN_DIGITS-1:0][SEG_W-1:0] segs;

    // calibration offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_centi <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_offset_centi <= i_cfg_data;
        end
    end

    // offset, scale and saturate
    adcseg_scale #(
        .ADC_BITS    (ADC_BITS),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_adc_sample   (i_adc_sample),
        .i_offset_centi (r_offset_centi),
        .o_valid        (mid_valid),
        .i_stall        (mid_stall),
        .o_value        (mid_value),
        .o_range        (mid_range)
    );

    // decimal digits and segment codes
    adcseg_digits #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_digits (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (mid_valid),
        .o_stall         (mid_stall),
        .i_value         (mid_value),
        .i_range         (mid_range),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_reading_centi (o_reading_centi),
        .o_segs          (segs),
        .o_range         (out_range)
    );

    assign o_seg_ones      = segs[0];
    assign o_seg_tens      = segs[1];
    assign o_seg_hundreds  = segs[2];
    assign o_seg_thousands = segs[3];
    assign o_over_range    = out_range.over;
    assign o_under_range   = out_range.under;

`ifndef SYNTHESIS
    // a reading cannot be both saturated and clamped
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_over_range && o_under_range))
        else $error("over and under range set together");

    // a clamped reading shows a single zero
    a_under_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_under_range) |->
            (o_reading_centi == '0 && o_seg_ones == seg_code(4'd0) && o_seg_tens == '0))
        else $error("clamped reading not shown as zero");

    // the ones digit is never blank
    a_ones_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_seg_ones != '0))
        else $error("ones digit blank");

    // no gap in the shown digits below a lit thousands digit
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_seg_thousands != '0) |-> (o_seg_hundreds != '0 && o_seg_tens != '0))
        else $error("blank digit below a shown one");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking bench for adc_to_seven_segment_temp; predicts every reading word
// from the sample and the calibration offset, checks each field, and varies idle and stall.
// Depends on adcseg_pkg and the adc_to_seven_segment_temp top level.
`timescale 1ns / 1ps

module tb_top
    import adcseg_pkg::*;
();

    // reading words in the display range top out at four nines
    localparam longint READING_MAX = 9999;
    localparam int     SETTLE_CYCLES = 10;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam logic [SEG_W-1:0] GLYPH [0:9] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct {
        logic [READING_W-1:0] reading;
        logic [SEG_W-1:0]     thousands;
        logic [SEG_W-1:0]     hundreds;
        logic [SEG_W-1:0]     tens;
        logic [SEG_W-1:0]     ones;
        logic                 over;
        logic                 under;
    } t_reading;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [OFFSET_W-1:0]     i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [ADC_BITS_DEF-1:0] i_adc_sample = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [READING_W-1:0]    o_reading_centi;
    logic [SEG_W-1:0]        o_seg_thousands;
    logic [SEG_W-1:0]        o_seg_hundreds;
    logic [SEG_W-1:0]        o_seg_tens;
    logic [SEG_W-1:0]        o_seg_ones;
    logic                    o_over_range;
    logic                    o_under_range;

    // bench copy of the calibration register
    logic [OFFSET_W-1:0] cal_offset = OFFSET_RESET;
    t_reading            expected_readings[$];
    int                  error_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  quiet_cycles = 0;

    adc_to_seven_segment_temp uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_adc_sample    (i_adc_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_reading_centi (o_reading_centi),
        .o_seg_thousands (o_seg_thousands),
        .o_seg_hundreds  (o_seg_hundreds),
        .o_seg_tens      (o_seg_tens),
        .o_seg_ones      (o_seg_ones),
        .o_over_range    (o_over_range),
        .o_under_range   (o_under_range)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // scale, clamp and split one sample into its display word
    function automatic t_reading predict_reading(input logic [ADC_BITS_DEF-1:0] sample,
                                                 input logic [OFFSET_W-1:0] offset);
        t_reading r;
        longint   numer;
        longint   off_l;
        longint   scaled;
        longint   rest;
        logic [SEG_W-1:0] segs [0:3];
        numer = sample;
        off_l = offset;
        numer = numer * SAMPLE_SCALE - off_l;
        // signed division truncates toward zero
        scaled = (numer * SCALE_NUM) / SCALE_DEN;
        r.over = 1'b0;
        r.under = 1'b0;
        if (scaled < 0) begin
            scaled = 0;
            r.under = 1'b1;
        end else if (scaled > READING_MAX) begin
            scaled = READING_MAX;
            r.over = 1'b1;
        end
        rest = scaled;
        // leading zeros blank, ones digit always lit
        for (int pos = 0; pos < 4; pos++) begin
            segs[pos] = (pos == 0 || rest != 0) ? GLYPH[rest % 10] : '0;
            rest = rest / 10;
        end
        r.reading = scaled[READING_W-1:0];
        r.thousands = segs[3];
        r.hundreds = segs[2];
        r.tens = segs[1];
        r.ones = segs[0];
        return r;
    endfunction

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // compare each accepted output word with the oldest prediction
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected word: reading_centi %0d", o_reading_centi);
                error_count++;
            end else begin
                want = expected_readings.pop_front();
                check_field("reading_centi", want.reading, o_reading_centi);
                check_field("seg_thousands", want.thousands, o_seg_thousands);
                check_field("seg_hundreds", want.hundreds, o_seg_hundreds);
                check_field("seg_tens", want.tens, o_seg_tens);
                check_field("seg_ones", want.ones, o_seg_ones);
                check_field("over_range", want.over, o_over_range);
                check_field("under_range", want.under, o_under_range);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // send one sample word, with random idle cycles ahead of it
    task automatic send_sample(input logic [ADC_BITS_DEF-1:0] sample);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_adc_sample <= sample;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        expected_readings.push_back(predict_reading(sample, cal_offset));
    endtask

    // hold off the sender until every predicted word has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // write the offset register with the pipeline empty
    task automatic set_offset(input logic [OFFSET_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cal_offset = value;
    endtask

    function automatic logic [OFFSET_W-1:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 17'd102300;
            2: return '1;
            3: return OFFSET_RESET;
            4: return OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
            default: return OFFSET_W'($urandom_range(0, 102300));
        endcase
    endfunction

    // mostly samples that land in the display window of the current offset
    function automatic logic [ADC_BITS_DEF-1:0] pick_sample();
        int s;
        if ($urandom_range(0, 9) < 7) begin
            s = int'(cal_offset / SAMPLE_SCALE) - 2 + $urandom_range(0, 130);
            if (s < 0) s = 0;
            if (s > 1023) s = 1023;
            return ADC_BITS_DEF'(s);
        end
        return ADC_BITS_DEF'($urandom_range(0, 1023));
    endfunction

    // reset offset: under range, in range, over range
    task automatic test_default_offset();
        send_sample(10'd0);
        send_sample(10'd324);
        send_sample(10'd325);
        send_sample(10'd512);
        send_sample(10'd1023);
    endtask

    // zero, one to four lit digits and saturation
    task automatic test_digit_widths();
        set_offset(17'd0);
        send_sample(10'd0);
        send_sample(10'd1);
        send_sample(10'd2);
        send_sample(10'd12);
        send_sample(10'd13);
        send_sample(10'd121);
        send_sample(10'd122);
        send_sample(10'd1023);
        set_offset(17'd90);
        send_sample(10'd1);
        send_sample(10'd0);
    endtask

    // numerator of minus one, exactly 9999, offsets at and above the top
    task automatic test_range_edges();
        set_offset(17'd1);
        send_sample(10'd0);
        send_sample(10'd122);
        send_sample(10'd123);
        set_offset(17'h1FFFF);
        send_sample(10'd0);
        send_sample(10'd1023);
        set_offset(17'd102300);
        send_sample(10'd1023);
        send_sample(10'd1022);
    endtask

    // random samples over several offsets, one pause to empty mid block
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_words);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int blk = 0; blk < 4; blk++) begin
            set_offset(pick_offset());
            for (int i = 0; i < n_words / 4; i++) begin
                if (i == n_words / 8) drain_results();
                send_sample(pick_sample());
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_offset();
        test_digit_widths();
        test_range_edges();
        test_random_traffic(0, 0, 460);
        test_random_traffic(46, 0, 460);
        test_random_traffic(0, 46, 460);
        test_random_traffic(9, 9, 460);
        drain_results();
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
